[rtl/core/swc_pkg.sv]
package swc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z = 3'd2;
    localparam logic [2:0] CFG_RADIUS   = 3'd3;
    localparam logic [2:0] CFG_SIDE     = 3'd4;

    localparam int SQ_CELLS = 32;   // one root bit per cell
    localparam int DV_CELLS = 30;   // one quotient bit per cell

    localparam int ST_S2    = 1;
    localparam int ST_S3    = 2;
    localparam int ST_SQ0   = 3;
    localparam int ST_S4    = ST_SQ0 + SQ_CELLS;
    localparam int ST_S5    = ST_S4 + 1;
    localparam int ST_DV0   = ST_S5 + 1;
    localparam int ST_OUT   = ST_DV0 + DV_CELLS;
    localparam int N_STAGES = ST_OUT + 1;

    typedef struct packed {
        logic [63:0]       s;
        logic [35:0]       rem;
        logic [31:0]       root;
        logic [2:0][31:0]  ad;
        logic [2:0]        sgn;
        logic [29:0]       reach;
    } sq_t;

    typedef struct packed {
        logic [2:0][61:0]  p;
        logic [2:0][32:0]  rem;
        logic [2:0][29:0]  q;
        logic [31:0]       r;
        logic [2:0]        sg;
        logic              in_sphere;
        logic              hit;
        logic              rzero;
        logic [30:0]       gap;
        logic [30:0]       curv;
    } dv_t;

endpackage

[rtl/core/swc_sqrt_cell.sv]
module swc_sqrt_cell #(
    parameter int IDX = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  swc_pkg::sq_t  din,
    output logic          vout,
    output swc_pkg::sq_t  dout
);
    import swc_pkg::*;

    logic        v_reg;
    sq_t         d_reg;
    sq_t         d_next;
    logic [35:0] cur;
    logic [35:0] trial;

    // bring down the next two radicand bits, try root*4+1
    always_comb
    begin
        d_next = din;
        cur    = {din.rem[33:0], din.s[2*IDX +: 2]};
        trial  = {2'b00, din.root, 2'b01};
        if (cur >= trial)
        begin
            d_next.rem  = cur - trial;
            d_next.root = {din.root[30:0], 1'b1};
        end
        else
        begin
            d_next.rem  = cur;
            d_next.root = {din.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

[rtl/core/swc_div_cell.sv]
module swc_div_cell #(
    parameter int BIT = 29
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  swc_pkg::dv_t  din,
    output logic          vout,
    output swc_pkg::dv_t  dout
);
    import swc_pkg::*;

    logic        v_reg;
    dv_t         d_reg;
    dv_t         d_next;
    logic [32:0] cur;

    // restoring division step on all three axes
    always_comb
    begin
        d_next = din;
        cur    = '0;
        for (int a = 0; a < 3; a++)
        begin
            cur = {din.rem[a][31:0], din.p[a][BIT]};
            if (cur >= {1'b0, din.r})
            begin
                d_next.rem[a] = cur - {1'b0, din.r};
                d_next.q[a]   = {din.q[a][28:0], 1'b1};
            end
            else
            begin
                d_next.rem[a] = cur;
                d_next.q[a]   = {din.q[a][28:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

[rtl/core/sphere_wall_contact_unit.sv]
// Sphere wall contact unit.
// Input stream (s_axis_*): one particle position plus a contact cutoff per
// request. Output stream (m_axis_*): one result per request, in order:
// inside/contact flags on tuser, gap, per-axis displacement and the signed
// wall radius on tdata.
// Configuration: write cfg_we/cfg_index/cfg_data only while the block is
// empty. The squared radius is re-registered every cycle from the radius.
// Pipeline: 3 front stages, 32 square-root cells, 2 scaling stages, 30 divider
// cells and an output register. Throughput: one request per cycle while the
// output is not held back; every stage is a register and the square-root and
// divider are rows of one-bit cells.
// Stall: each stage loads when it is empty or the stage after it moves, so
// bubbles are squeezed out and s_axis_tready stays high while the output
// register holds a result and the pipe still has a free slot.
// Reset: all valid bits and configuration registers clear; radius 0,
// centre at the origin, inner-surface test.
module sphere_wall_contact_unit (
    input  logic          clk,
    input  logic          rst_n,
    // s_axis_tdata: pos_x[30:0], pos_y[61:31], pos_z[92:62], reach[122:93]
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,
    // m_axis_tdata: gap[30:0], disp_x[62:31], disp_y[94:63], disp_z[126:95],
    //               wall_curvature[157:127]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [159:0]  m_axis_tdata,
    // m_axis_tuser: inside_flag[0], contact_flag[1]
    output logic [1:0]    m_axis_tuser,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [30:0]   cfg_data
);
    import swc_pkg::*;

    // configuration
    logic [30:0] cx_reg, cy_reg, cz_reg;
    logic [29:0] rad_reg;
    logic        side_reg;
    logic [63:0] r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
            rad_reg  <= '0;
            side_reg <= 1'b0;
            r2_reg   <= '0;
        end
        else
        begin
            r2_reg <= {34'b0, rad_reg} * {34'b0, rad_reg};
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CENTER_X: cx_reg   <= cfg_data;
                    CFG_CENTER_Y: cy_reg   <= cfg_data;
                    CFG_CENTER_Z: cz_reg   <= cfg_data;
                    CFG_RADIUS:   rad_reg  <= cfg_data[29:0];
                    CFG_SIDE:     side_reg <= cfg_data[0];
                    default:      ;
                endcase
            end
        end
    end

    // stage enables: a stage loads when empty or when its successor loads
    logic [N_STAGES-1:0] vld;
    logic [N_STAGES-1:0] en;

    genvar gi;
    generate
        for (gi = 0; gi < N_STAGES - 1; gi++)
        begin : g_en
            assign en[gi] = !vld[gi] || en[gi+1];
        end
    endgenerate
    assign en[ST_OUT] = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en[0];

    // stage 1: offsets from the centre
    logic signed [31:0] d1_reg [3];
    logic [29:0]        reach1_reg;
    logic               v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en[0])
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d1_reg[0]  <= $signed({s_axis_tdata[30], s_axis_tdata[30:0]})
                        - $signed({cx_reg[30], cx_reg});
            d1_reg[1]  <= $signed({s_axis_tdata[61], s_axis_tdata[61:31]})
                        - $signed({cy_reg[30], cy_reg});
            d1_reg[2]  <= $signed({s_axis_tdata[92], s_axis_tdata[92:62]})
                        - $signed({cz_reg[30], cz_reg});
            reach1_reg <= s_axis_tdata[122:93];
        end
    end
    assign vld[0] = v1_reg;

    // stage 2: magnitudes and squares
    logic [31:0] ad1 [3];
    logic [63:0] sq2_reg [3];
    logic [31:0] ad2_reg [3];
    logic [2:0]  sgn2_reg;
    logic [29:0] reach2_reg;
    logic        v2_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            ad1[a] = d1_reg[a][31] ? 32'(-d1_reg[a]) : 32'(d1_reg[a]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en[ST_S2])
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_S2])
        begin
            for (int a = 0; a < 3; a++)
            begin
                sq2_reg[a]  <= {32'b0, ad1[a]} * {32'b0, ad1[a]};
                ad2_reg[a]  <= ad1[a];
                sgn2_reg[a] <= d1_reg[a][31];
            end
            reach2_reg <= reach1_reg;
        end
    end
    assign vld[ST_S2] = v2_reg;

    // stage 3: squared distance, seed of the root chain
    sq_t  sq [SQ_CELLS+1];
    logic sqv [SQ_CELLS+1];
    sq_t  sq3_reg;
    logic v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en[ST_S3])
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_S3])
        begin
            sq3_reg.s     <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            sq3_reg.rem   <= '0;
            sq3_reg.root  <= '0;
            sq3_reg.ad[0] <= ad2_reg[0];
            sq3_reg.ad[1] <= ad2_reg[1];
            sq3_reg.ad[2] <= ad2_reg[2];
            sq3_reg.sgn   <= sgn2_reg;
            sq3_reg.reach <= reach2_reg;
        end
    end
    assign vld[ST_S3] = v3_reg;
    assign sq[0]  = sq3_reg;
    assign sqv[0] = v3_reg;

    // square root: one root bit per cell, MSB first
    generate
        for (gi = 0; gi < SQ_CELLS; gi++)
        begin : g_sq
            swc_sqrt_cell #(.IDX(SQ_CELLS - 1 - gi)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en[ST_SQ0+gi]),
                .vin   (sqv[gi]),
                .din   (sq[gi]),
                .vout  (sqv[gi+1]),
                .dout  (sq[gi+1])
            );
            assign vld[ST_SQ0+gi] = sqv[gi+1];
        end
    endgenerate

    // stage 4: inside test, contact test, gap
    sq_t         sqo;
    logic        inside4;
    logic        cond4;
    logic [32:0] gap33;
    logic        hit4;

    assign sqo = sq[SQ_CELLS];

    always_comb
    begin
        inside4 = sqo.s <= r2_reg;
        if (!side_reg)
        begin
            cond4 = inside4 && (sqo.s != 64'd0);
            gap33 = {3'b0, rad_reg} - {1'b0, sqo.root};
        end
        else
        begin
            cond4 = sqo.s >= r2_reg;
            gap33 = {1'b0, sqo.root} - {3'b0, rad_reg};
        end
        hit4 = cond4 && (gap33 < {3'b0, sqo.reach});
    end

    logic        v4_reg;
    logic        inside4_reg, hit4_reg, neg4_reg;
    logic [29:0] geff4_reg;
    logic [31:0] r4_reg;
    logic [31:0] ad4_reg [3];
    logic [2:0]  sgn4_reg;
    logic [30:0] curv4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en[ST_S4])
            v4_reg <= sqv[SQ_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_S4])
        begin
            inside4_reg <= inside4;
            hit4_reg    <= hit4;
            neg4_reg    <= !side_reg;
            geff4_reg   <= hit4 ? gap33[29:0] : 30'd0;
            r4_reg      <= sqo.root;
            for (int a = 0; a < 3; a++)
                ad4_reg[a] <= sqo.ad[a];
            sgn4_reg    <= sqo.sgn;
            // signed wall radius, zero without contact
            curv4_reg   <= !hit4 ? 31'd0
                         : (!side_reg ? 31'(-{1'b0, rad_reg}) : {1'b0, rad_reg});
        end
    end
    assign vld[ST_S4] = v4_reg;

    // stage 5: numerators |d|*gap, seed of the divider chain
    dv_t  dv [DV_CELLS+1];
    logic dvv [DV_CELLS+1];
    dv_t  dv5_next;
    dv_t  dv5_reg;
    logic v5_reg;
    logic [61:0] prod5 [3];

    always_comb
    begin
        dv5_next = '0;
        for (int a = 0; a < 3; a++)
        begin
            prod5[a]        = ad4_reg[a] * geff4_reg;
            dv5_next.p[a]   = prod5[a];
            dv5_next.rem[a] = {1'b0, prod5[a][61:30]};
            dv5_next.sg[a]  = sgn4_reg[a] ^ neg4_reg;
        end
        dv5_next.r         = r4_reg;
        dv5_next.in_sphere = inside4_reg;
        dv5_next.hit       = hit4_reg;
        dv5_next.rzero     = r4_reg == 32'd0;
        dv5_next.gap       = {1'b0, geff4_reg};
        dv5_next.curv      = curv4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en[ST_S5])
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_S5])
            dv5_reg <= dv5_next;
    end
    assign vld[ST_S5] = v5_reg;
    assign dv[0]  = dv5_reg;
    assign dvv[0] = v5_reg;

    // divider by r: one quotient bit per cell, MSB first
    generate
        for (gi = 0; gi < DV_CELLS; gi++)
        begin : g_dv
            swc_div_cell #(.BIT(DV_CELLS - 1 - gi)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en[ST_DV0+gi]),
                .vin   (dvv[gi]),
                .din   (dv[gi]),
                .vout  (dvv[gi+1]),
                .dout  (dv[gi+1])
            );
            assign vld[ST_DV0+gi] = dvv[gi+1];
        end
    endgenerate

    // output register: sign the quotients
    dv_t         dvo;
    logic [31:0] disp [3];
    logic        ov_reg;
    logic [159:0] odata_reg;
    logic [1:0]   ouser_reg;

    assign dvo = dv[DV_CELLS];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (!dvo.hit || dvo.rzero)
                disp[a] = '0;
            else if (dvo.sg[a])
                disp[a] = 32'(-{2'b0, dvo.q[a]});
            else
                disp[a] = {2'b0, dvo.q[a]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en[ST_OUT])
            ov_reg <= dvv[DV_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            odata_reg <= {2'b0, dvo.curv, disp[2], disp[1], disp[0], dvo.gap};
            ouser_reg <= {dvo.hit, dvo.in_sphere};
        end
    end
    assign vld[ST_OUT]   = ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = ouser_reg;

    // no contact means an all-zero payload
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata == 160'd0)
        else $error("payload not cleared without contact");

    // inner contact only for points inside the sphere
    a_inner_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] && !side_reg |-> m_axis_tuser[0])
        else $error("inner contact outside the sphere");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

endmodule

[tb/sphere_wall_contact_unit_test.sv]
`timescale 1ns / 100ps

module sphere_wall_contact_unit_test;
    import swc_pkg::*;

    localparam int PIPE_LATENCY = 68;

    typedef struct packed {
        logic [29:0] reach;
        logic [30:0] pos_z;
        logic [30:0] pos_y;
        logic [30:0] pos_x;
    } particle_t;

    typedef struct packed {
        logic        in_sphere;
        logic        contact;
        logic [30:0] gap;
        logic [31:0] disp_x;
        logic [31:0] disp_y;
        logic [31:0] disp_z;
        logic [30:0] curv;
    } contact_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [30:0]  cfg_data;

    // sphere settings as the predictor sees them
    logic signed [30:0] ctr_x, ctr_y, ctr_z;
    logic [29:0]        radius;
    logic               outer_side;

    particle_t particle_q[$];   // requests waiting for the driver
    contact_t  contact_q[$];    // predicted results, oldest first

    int  errors;
    int  gap_cnt;
    int  hold_cnt;
    bit  hold_req;

    sphere_wall_contact_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // d * gap / r truncated toward zero, sign flipped for the inner wall
    function automatic logic [31:0] surface_offset(input longint d, input logic [63:0] g,
                                                   input bit flip, input logic [63:0] r);
        logic [63:0] mag;
        logic [63:0] ad;
        if (r == 0)
            return 32'd0;
        ad  = (d < 0) ? -d : d;
        mag = (ad * g) / r;
        return 32'(((d < 0) != flip) ? -mag : mag);
    endfunction

    function automatic contact_t predict_contact(input particle_t p);
        contact_t    c;
        longint      dx, dy, dz;
        logic [63:0] ssq, rsq, r, g;
        bit          in_sph, hit, flip;
        dx     = longint'($signed(p.pos_x)) - longint'(ctr_x);
        dy     = longint'($signed(p.pos_y)) - longint'(ctr_y);
        dz     = longint'($signed(p.pos_z)) - longint'(ctr_z);
        ssq    = dx * dx + dy * dy + dz * dz;
        rsq    = 64'(radius) * 64'(radius);
        r      = int_sqrt(ssq);
        in_sph = ssq <= rsq;
        hit    = 0;
        flip   = 0;
        g      = 0;
        if (!outer_side)
        begin
            if (in_sph && ssq != 0)
            begin
                g    = 64'(radius) - r;
                flip = 1;
                hit  = g < 64'(p.reach);
            end
        end
        else if (ssq >= rsq)
        begin
            g   = r - 64'(radius);
            hit = g < 64'(p.reach);
        end
        c           = '0;
        c.in_sphere = in_sph;
        c.contact   = hit;
        if (hit)
        begin
            c.gap    = g[30:0];
            c.disp_x = surface_offset(dx, g, flip, r);
            c.disp_y = surface_offset(dy, g, flip, r);
            c.disp_z = surface_offset(dz, g, flip, r);
            c.curv   = flip ? 31'(-{1'b0, radius}) : {1'b0, radius};
        end
        return c;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_cnt       <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_cnt > 0)
            begin
                gap_cnt       <= gap_cnt - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (particle_q.size() > 0)
            begin
                s_axis_tdata  <= {5'd0, particle_q.pop_front()};
                s_axis_tvalid <= 1'b1;
                case ($urandom_range(0, 9))
                    0, 1:    gap_cnt <= $urandom_range(1, 3);
                    2:       gap_cnt <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : 0;
                    default: gap_cnt <= 0;
                endcase
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        contact_t got;
        contact_t exp_c;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.in_sphere = m_axis_tuser[0];
                got.contact   = m_axis_tuser[1];
                got.gap       = m_axis_tdata[30:0];
                got.disp_x    = m_axis_tdata[62:31];
                got.disp_y    = m_axis_tdata[94:63];
                got.disp_z    = m_axis_tdata[126:95];
                got.curv      = m_axis_tdata[157:127];
                if (contact_q.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    exp_c = contact_q.pop_front();
                    if (got !== exp_c)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("mismatch: inside %b/%b contact %b/%b gap %h/%h dx %h/%h dy %h/%h dz %h/%h curv %h/%h",
                                     exp_c.in_sphere, got.in_sphere, exp_c.contact, got.contact,
                                     exp_c.gap, got.gap, exp_c.disp_x, got.disp_x,
                                     exp_c.disp_y, got.disp_y, exp_c.disp_z, got.disp_z,
                                     exp_c.curv, got.curv);
                    end
                end
            end
            // long hold-off so the pipe fills and stalls the input
            if (hold_req)
            begin
                hold_req      = 0;
                hold_cnt      <= 300;
                m_axis_tready <= 1'b0;
            end
            else if (hold_cnt > 1)
            begin
                hold_cnt      <= hold_cnt - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2:
                    begin
                        m_axis_tready <= 1'b0;
                        hold_cnt      <= 0;
                    end
                    3:
                    begin
                        m_axis_tready <= 1'b0;
                        hold_cnt      <= $urandom_range(5, 30);
                    end
                    default:
                    begin
                        m_axis_tready <= 1'b1;
                        hold_cnt      <= 0;
                    end
                endcase
            end
        end
    end

    // every request queued is predicted at once; config only changes when idle
    task automatic queue_particle(input particle_t p);
        particle_q.push_back(p);
        contact_q.push_back(predict_contact(p));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_CENTER_X: ctr_x      = val;
            CFG_CENTER_Y: ctr_y      = val;
            CFG_CENTER_Z: ctr_z      = val;
            CFG_RADIUS:   radius     = val[29:0];
            CFG_SIDE:     outer_side = val[0];
            default: ;
        endcase
    endtask

    task automatic drain;
        while (particle_q.size() > 0 || contact_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [30:0] rand31();
        case ($urandom_range(0, 5))
            0:       return 31'h3FFF_FFFF;
            1:       return 31'h4000_0000;
            default: return 31'($urandom());
        endcase
    endfunction

    // point near the wall: centre plus radius +/- span on one random axis and small random offsets on the others
    task automatic queue_near_wall(input int span);
        particle_t   p;
        longint      len, ox, oy, oz;
        int          k;
        len = longint'(radius) + $signed($urandom_range(0, 2 * span)) - span;
        k   = $urandom_range(0, 2);
        ox  = $signed($urandom_range(0, 2000)) - 1000;
        oy  = $signed($urandom_range(0, 2000)) - 1000;
        oz  = $signed($urandom_range(0, 2000)) - 1000;
        if (k == 0) ox = (ox < 0) ? -len : len;
        else if (k == 1) oy = (oy < 0) ? -len : len;
        else oz = (oz < 0) ? -len : len;
        p.pos_x = 31'(longint'(ctr_x) + ox);
        p.pos_y = 31'(longint'(ctr_y) + oy);
        p.pos_z = 31'(longint'(ctr_z) + oz);
        p.reach = ($urandom_range(0, 9) == 0) ? 30'($urandom())
                                              : 30'($urandom_range(0, 2 * span + 2));
        queue_particle(p);
    endtask

    initial
    begin
        particle_t p;
        int        phase, n;
        errors = 0;
        hold_req = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CENTER_X;
        cfg_data = '0;
        ctr_x = 0; ctr_y = 0; ctr_z = 0; radius = 0; outer_side = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, point at centre, field extremes
        queue_particle('0);
        p = '0; p.reach = 30'h3FFF_FFFF; queue_particle(p);
        p = '{reach: 30'h3FFF_FFFF, pos_z: 31'h4000_0000, pos_y: 31'h4000_0000,
              pos_x: 31'h4000_0000};
        queue_particle(p);
        p = '{reach: 30'h3FFF_FFFF, pos_z: 31'h3FFF_FFFF, pos_y: 31'h3FFF_FFFF,
              pos_x: 31'h3FFF_FFFF};
        queue_particle(p);
        drain();
        write_reg(CFG_SIDE, 31'd1);
        queue_particle('0);           // outer, zero radius, at centre
        p = '0; p.reach = 30'd1; queue_particle(p);
        p = '{reach: 30'h3FFF_FFFF, pos_z: 31'h7FFF_0000, pos_y: 31'h0001_0000,
              pos_x: 31'h4000_0000};
        queue_particle(p);
        drain();
        write_reg(CFG_RADIUS, 31'h3FFF_FFFF);
        write_reg(CFG_CENTER_X, 31'h4000_0000);
        write_reg(CFG_CENTER_Y, 31'h3FFF_FFFF);
        write_reg(CFG_CENTER_Z, 31'h4000_0000);
        write_reg(3'd7, 31'h1234);   // ignored index
        for (int i = 0; i < 6; i++) queue_near_wall(100);
        p = '{reach: 30'h3FFF_FFFF, pos_z: 31'h3FFF_FFFF, pos_y: 31'h4000_0000,
              pos_x: 31'h3FFF_FFFF};
        queue_particle(p);
        drain();
        write_reg(CFG_SIDE, 31'd0);
        for (int i = 0; i < 6; i++) queue_near_wall(100);
        queue_particle('{reach: 30'h3FFF_FFFF, pos_z: ctr_z, pos_y: ctr_y, pos_x: ctr_x});
        drain();

        // random phases with new sphere settings each time; the held phase
        // queues more requests than the pipe holds
        for (phase = 0; phase < 8; phase++)
        begin
            write_reg(CFG_CENTER_X, rand31());
            write_reg(CFG_CENTER_Y, rand31());
            write_reg(CFG_CENTER_Z, rand31());
            case (phase % 4)
                0:       write_reg(CFG_RADIUS, 31'h3FFF_FFFF);
                1:       write_reg(CFG_RADIUS, 31'd0);
                default: write_reg(CFG_RADIUS, 31'($urandom_range(1, 32'h3FFF_FFFF)));
            endcase
            write_reg(CFG_SIDE, 31'(phase[0]));
            if (phase == 2)
                hold_req = 1;
            for (n = 0; n < ((phase == 2) ? 120 : 40); n++)
            begin
                if ($urandom_range(0, 3) != 0)
                    queue_near_wall(($urandom_range(0, 1) != 0) ? 64 : 65536);
                else
                begin
                    p.pos_x = rand31();
                    p.pos_y = rand31();
                    p.pos_z = rand31();
                    p.reach = ($urandom_range(0, 4) == 0) ? 30'h3FFF_FFFF : 30'($urandom());
                    queue_particle(p);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule

[sphere_wall_contact_unit.f]
rtl/core/swc_pkg.sv
rtl/core/swc_sqrt_cell.sv
rtl/core/swc_div_cell.sv
rtl/core/sphere_wall_contact_unit.sv
tb/sphere_wall_contact_unit_test.sv
